[sv/rcd_pkg.sv]
// package for the chunk stream deframer: widths, codes and result type
`timescale 1ns / 1ps
package rcd_pkg;
  localparam int unsigned SLOTS = 8;
  localparam int unsigned SLOT_W = 3;
  localparam logic [3:0] POS_BASIC = 4'd0;
  localparam logic [3:0] POS_PAYLOAD = 4'd15;
  localparam logic [23:0] RESET_CHUNK = 24'd128;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_EXT_ID = 2'd1,
    ERR_FULL = 2'd2,
    ERR_NO_HDR = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [5:0]  channel;
    logic [7:0]  message_type;
    logic [31:0] timestamp;
    logic [23:0] message_length;
    logic        first_of_message;
    logic        last_of_message;
    logic [1:0]  error;
  } result_t;
endpackage

[sv/rcd_if.sv]
// valid/ready channel interfaces for input items, results and configuration
`timescale 1ns / 1ps
interface rcd_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] stream_byte;
  modport source (output valid, mode, stream_byte, input ready);
  modport sink (input valid, mode, stream_byte, output ready);
endinterface

interface rcd_out_if (input logic clk);
  logic             valid;
  logic             ready;
  rcd_pkg::result_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface rcd_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/rtmp_chunk_deframer_unit.sv]
// top level of the chunk stream deframer
//
// in_ch: one transfer per stream byte (mode 0) or session clear (mode 1).
// out_ch: one transfer per payload byte or per header error, carrying the
//   channel, type, absolute timestamp, length and first/last marks.
// cfg_ch: writes initial_chunk_size; it takes effect at the next session
//   clear. Write only while idle.
// Each input transfer is processed by the header parser and the 8-slot
// channel cache with parallel compare; a result enters the output register
// in the cycle after its input transfer. Throughput is one byte per cycle
// while no result waits on a low out_ready, as the cache updates per byte.
// The output register takes a new result whenever it is empty or being
// drained, so in_ready drops only while a result waits and the receiver
// holds out_ready low.
// Synchronous reset (rst_n low) clears the cache and parser and loads a
// chunk size of 128; initial_chunk_size returns to 128.
`timescale 1ns / 1ps
module rtmp_chunk_deframer_unit (
  input logic      clk,
  input logic      rst_n,
  rcd_in_if.sink   in_ch,
  rcd_out_if.source out_ch,
  rcd_cfg_if.sink  cfg_ch
);
  logic [5:0]  slot_chan_r [rcd_pkg::SLOTS];
  logic [7:0]  slot_type_r [rcd_pkg::SLOTS];
  logic [23:0] slot_len_r [rcd_pkg::SLOTS];
  logic [23:0] slot_rem_r [rcd_pkg::SLOTS];
  logic [31:0] slot_ts_r [rcd_pkg::SLOTS];
  logic [23:0] slot_delta_r [rcd_pkg::SLOTS];
  logic        slot_known_r [rcd_pkg::SLOTS];
  logic [3:0]  pos_r;
  logic [1:0]  fmt_r;
  logic [rcd_pkg::SLOT_W-1:0] cur_r;
  logic [23:0] shift_r;
  logic [23:0] cbl_r;
  logic [31:0] acs_r;
  logic [31:0] cap_r;
  logic [23:0] init_r;
  logic        ov_r;
  rcd_pkg::result_t od_r;

  logic fire;
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;

  logic [7:0] b;
  logic [5:0] chan;
  logic [1:0] fmt;
  logic       hit;
  logic       free;
  logic [rcd_pkg::SLOT_W-1:0] hit_s;
  logic [rcd_pkg::SLOT_W-1:0] free_s;
  assign b = in_ch.stream_byte;
  assign chan = b[5:0];
  assign fmt = b[7:6];

  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_s = '0;
    free_s = '0;
    for (int i = rcd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (slot_chan_r[i] == chan) begin
        hit = 1'b1;
        hit_s = i[rcd_pkg::SLOT_W-1:0];
      end
      if (slot_chan_r[i] == 6'd0) begin
        free = 1'b1;
        free_s = i[rcd_pkg::SLOT_W-1:0];
      end
    end
  end

  logic [23:0] shift_new;
  logic [23:0] rem_m1;
  logic [23:0] offs;
  logic [31:0] cap_new;
  logic [23:0] acs24;
  assign shift_new = {shift_r[15:0], b};
  assign rem_m1 = slot_rem_r[cur_r] - 24'd1;
  assign offs = slot_len_r[cur_r] - slot_rem_r[cur_r];
  assign acs24 = (acs_r[31:24] != 8'd0) ? 24'hffffff : acs_r[23:0];

  always_comb begin
    cap_new = (offs == 24'd0) ? 32'd0 : cap_r;
    if (offs < 24'd4) cap_new = {cap_new[23:0], b};
  end

  function automatic logic [23:0] min_chunk(input logic [23:0] r, input logic [23:0] a);
    min_chunk = (r < a) ? r : a;
  endfunction

  always_ff @(posedge clk) begin
    logic [rcd_pkg::SLOT_W-1:0] s;
    logic        done;
    logic [23:0] rem;
    rcd_pkg::result_t res;
    logic        emit;
    logic [3:0]  pos_nxt;
    logic        ov_nxt;
    s = '0;
    done = 1'b0;
    rem = '0;
    res = '0;
    emit = 1'b0;
    pos_nxt = pos_r;
    ov_nxt = ov_r;
    if (!rst_n) begin
      for (int i = 0; i < rcd_pkg::SLOTS; i++) begin
        slot_chan_r[i] <= '0; slot_type_r[i] <= '0; slot_len_r[i] <= '0;
        slot_rem_r[i] <= '0; slot_ts_r[i] <= '0; slot_delta_r[i] <= '0;
        slot_known_r[i] <= 1'b0;
      end
      pos_r <= rcd_pkg::POS_BASIC; fmt_r <= '0; cur_r <= '0; shift_r <= '0;
      cbl_r <= '0; cap_r <= '0; acs_r <= {8'd0, rcd_pkg::RESET_CHUNK};
      init_r <= rcd_pkg::RESET_CHUNK; ov_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) init_r <= cfg_ch.data;
      if (out_ch.ready) ov_nxt = 1'b0;
      if (fire) begin
        if (in_ch.mode) begin
          for (int i = 0; i < rcd_pkg::SLOTS; i++) begin
            slot_chan_r[i] <= '0; slot_type_r[i] <= '0; slot_len_r[i] <= '0;
            slot_rem_r[i] <= '0; slot_ts_r[i] <= '0; slot_delta_r[i] <= '0;
            slot_known_r[i] <= 1'b0;
          end
          pos_nxt = rcd_pkg::POS_BASIC; fmt_r <= '0; cur_r <= '0; shift_r <= '0;
          cbl_r <= '0; cap_r <= '0;
          acs_r <= (init_r == 24'd0) ? 32'd1 : {8'd0, init_r};
        end else if (pos_r == rcd_pkg::POS_PAYLOAD) begin
          s = cur_r;
          cap_r <= cap_new;
          slot_rem_r[s] <= rem_m1;
          cbl_r <= cbl_r - 24'd1;
          emit = 1'b1;
          res.payload_byte = b;
          res.channel = slot_chan_r[s];
          res.message_type = slot_type_r[s];
          res.timestamp = slot_ts_r[s];
          res.message_length = slot_len_r[s];
          res.first_of_message = (offs == 24'd0);
          res.last_of_message = (rem_m1 == 24'd0);
          res.error = rcd_pkg::ERR_NONE;
          if (rem_m1 == 24'd0 && slot_type_r[s] == 8'd1 && slot_len_r[s] >= 24'd4
              && cap_new[30:0] != 31'd0)
            acs_r <= {1'b0, cap_new[30:0]};
          if (rem_m1 == 24'd0 || cbl_r == 24'd1) pos_nxt = rcd_pkg::POS_BASIC;
        end else if (pos_r == rcd_pkg::POS_BASIC || pos_r > 4'd11) begin
          pos_nxt = rcd_pkg::POS_BASIC;
          res.channel = chan;
          if (chan < 6'd2) begin
            emit = 1'b1;
            res.error = rcd_pkg::ERR_EXT_ID;
          end else if (!hit && !free) begin
            emit = 1'b1;
            res.error = rcd_pkg::ERR_FULL;
          end else begin
            s = hit ? hit_s : free_s;
            slot_chan_r[s] <= chan;
            cur_r <= s;
            fmt_r <= fmt;
            shift_r <= '0;
            if (fmt != 2'd3) begin
              if (fmt == 2'd2 && !slot_known_r[s]) begin
                emit = 1'b1;
                res.error = rcd_pkg::ERR_NO_HDR;
              end else pos_nxt = 4'd1;
            end else if (slot_rem_r[s] != 24'd0) begin
              cbl_r <= min_chunk(slot_rem_r[s], acs24);
              pos_nxt = rcd_pkg::POS_PAYLOAD;
            end else if (slot_known_r[s]) begin
              slot_ts_r[s] <= slot_ts_r[s] + {8'd0, slot_delta_r[s]};
              slot_rem_r[s] <= slot_len_r[s];
              if (slot_len_r[s] != 24'd0) begin
                cbl_r <= min_chunk(slot_len_r[s], acs24);
                pos_nxt = rcd_pkg::POS_PAYLOAD;
              end
            end else begin
              emit = 1'b1;
              res.error = rcd_pkg::ERR_NO_HDR;
            end
          end
        end else begin
          s = cur_r;
          shift_r <= shift_new;
          pos_nxt = pos_r + 4'd1;
          if (pos_r == 4'd3) begin
            slot_delta_r[s] <= shift_new;
            if (fmt_r == 2'd0) slot_ts_r[s] <= {8'd0, shift_new};
            else begin
              slot_ts_r[s] <= slot_ts_r[s] + {8'd0, shift_new};
              done = (fmt_r == 2'd2);
            end
          end else if (pos_r == 4'd6) begin
            slot_len_r[s] <= shift_new;
          end else if (pos_r == 4'd7) begin
            slot_type_r[s] <= b;
            done = (fmt_r == 2'd1);
          end else if (pos_r == 4'd11) begin
            done = 1'b1;
          end
          if (done) begin
            slot_known_r[s] <= 1'b1;
            rem = (pos_r == 4'd6) ? shift_new : slot_len_r[s];
            slot_rem_r[s] <= rem;
            if (rem == 24'd0) pos_nxt = rcd_pkg::POS_BASIC;
            else begin
              cbl_r <= min_chunk(rem, acs24);
              pos_nxt = rcd_pkg::POS_PAYLOAD;
            end
          end
        end
        if (emit) begin
          ov_nxt = 1'b1;
          od_r <= res;
        end
      end
      pos_r <= pos_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

[sim/rtmp_chunk_deframer_unit_tb.sv]
// testbench for rtmp_chunk_deframer_unit: chunk stream stimulus, predicted payload and errors
`timescale 1ns / 1ps
module rtmp_chunk_deframer_unit_tb;

  class deframe_scoreboard;
    logic [5:0]  slot_ch[rcd_pkg::SLOTS];
    logic [7:0]  slot_ty[rcd_pkg::SLOTS];
    logic [23:0] slot_len[rcd_pkg::SLOTS];
    logic [23:0] slot_rem[rcd_pkg::SLOTS];
    logic [31:0] slot_ts[rcd_pkg::SLOTS];
    logic [23:0] slot_dl[rcd_pkg::SLOTS];
    bit          slot_kn[rcd_pkg::SLOTS];
    logic [3:0]  pos;
    logic [1:0]  fmt;
    int          cur;
    logic [23:0] field;
    logic [23:0] chunk_left;
    logic [31:0] chunk_size;
    logic [31:0] size_capture;
    logic [23:0] init_size;
    rcd_pkg::result_t pending[$];
    int          mismatches;

    function new();
      init_size = rcd_pkg::RESET_CHUNK;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      for (int i = 0; i < rcd_pkg::SLOTS; i++) begin
        slot_ch[i] = '0; slot_ty[i] = '0; slot_len[i] = '0; slot_rem[i] = '0;
        slot_ts[i] = '0; slot_dl[i] = '0; slot_kn[i] = 1'b0;
      end
      pos = rcd_pkg::POS_BASIC;
      fmt = '0;
      cur = 0;
      field = '0;
      chunk_left = '0;
      size_capture = '0;
      chunk_size = (init_size != 24'd0) ? {8'd0, init_size} : 32'd1;
    endfunction

    function int find(logic [5:0] c);
      for (int i = 0; i < rcd_pkg::SLOTS; i++)
        if (slot_ch[i] == c) return i;
      return -1;
    endfunction

    function void flag(logic [5:0] c, rcd_pkg::err_t e);
      rcd_pkg::result_t r;
      r = '0;
      r.channel = c;
      r.error = e;
      pending.push_back(r);
      pos = rcd_pkg::POS_BASIC;
    endfunction

    function void open_chunk(int s);
      chunk_left = ({8'd0, slot_rem[s]} < chunk_size) ? slot_rem[s] : chunk_size[23:0];
      pos = rcd_pkg::POS_PAYLOAD;
    endfunction

    function void open_message(int s);
      slot_rem[s] = slot_len[s];
      if (slot_rem[s] == 24'd0) pos = rcd_pkg::POS_BASIC;
      else open_chunk(s);
    endfunction

    function void basic(logic [7:0] b);
      logic [5:0] c;
      logic [1:0] f;
      int s;
      int fr;
      c = b[5:0];
      f = b[7:6];
      s = -1;
      fr = -1;
      if (c < 6'd2) begin
        flag(c, rcd_pkg::ERR_EXT_ID);
        return;
      end
      for (int i = 0; i < rcd_pkg::SLOTS; i++) begin
        if (slot_ch[i] == c) begin
          s = i;
          break;
        end
        if (slot_ch[i] == 6'd0 && fr < 0) fr = i;
      end
      if (s < 0) begin
        if (fr < 0) begin
          flag(c, rcd_pkg::ERR_FULL);
          return;
        end
        s = fr;
        slot_ch[s] = c;
      end
      cur = s;
      fmt = f;
      field = '0;
      if (f < 2'd3) begin
        if (f == 2'd2 && !slot_kn[s]) flag(c, rcd_pkg::ERR_NO_HDR);
        else pos = 4'd1;
      end else if (slot_rem[s] != 24'd0) begin
        open_chunk(s);
      end else if (slot_kn[s]) begin
        slot_ts[s] += {8'd0, slot_dl[s]};
        open_message(s);
      end else begin
        flag(c, rcd_pkg::ERR_NO_HDR);
      end
    endfunction

    function void header(logic [7:0] b);
      bit done;
      done = 1'b0;
      field = {field[15:0], b};
      if (pos == 4'd3) begin
        if (fmt == 2'd0) begin
          slot_ts[cur] = {8'd0, field};
          slot_dl[cur] = field;
        end else begin
          slot_dl[cur] = field;
          slot_ts[cur] += {8'd0, field};
          if (fmt == 2'd2) done = 1'b1;
        end
      end else if (pos == 4'd6) begin
        slot_len[cur] = field;
      end else if (pos == 4'd7) begin
        slot_ty[cur] = b;
        if (fmt == 2'd1) done = 1'b1;
      end else if (pos >= 4'd11) begin
        done = 1'b1;
      end
      if (done) begin
        slot_kn[cur] = 1'b1;
        open_message(cur);
      end else begin
        pos = pos + 4'd1;
      end
    endfunction

    function void payload(logic [7:0] b);
      rcd_pkg::result_t r;
      logic [23:0] ln;
      logic [23:0] off;
      logic [31:0] v;
      ln = slot_len[cur];
      off = ln - slot_rem[cur];
      if (off == 24'd0) size_capture = '0;
      if (off < 24'd4) size_capture = {size_capture[23:0], b};
      slot_rem[cur] = slot_rem[cur] - 24'd1;
      chunk_left = chunk_left - 24'd1;
      r.payload_byte = b;
      r.channel = slot_ch[cur];
      r.message_type = slot_ty[cur];
      r.timestamp = slot_ts[cur];
      r.message_length = ln;
      r.first_of_message = (off == 24'd0);
      r.last_of_message = (slot_rem[cur] == 24'd0);
      r.error = rcd_pkg::ERR_NONE;
      pending.push_back(r);
      if (r.last_of_message && slot_ty[cur] == 8'd1 && ln >= 24'd4) begin
        v = size_capture & 32'h7fff_ffff;
        if (v != 32'd0) chunk_size = v;
      end
      if (r.last_of_message || chunk_left == 24'd0) pos = rcd_pkg::POS_BASIC;
    endfunction

    function void note_input(logic m, logic [7:0] b);
      if (m) clear();
      else if (pos == rcd_pkg::POS_BASIC) basic(b);
      else if (pos == rcd_pkg::POS_PAYLOAD) payload(b);
      else if (pos > 4'd11) begin
        pos = rcd_pkg::POS_BASIC;
        basic(b);
      end else header(b);
    endfunction

    function void check_result(rcd_pkg::result_t got);
      rcd_pkg::result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.payload_byte !== want.payload_byte || got.channel !== want.channel ||
          got.message_type !== want.message_type || got.timestamp !== want.timestamp ||
          got.message_length !== want.message_length ||
          got.first_of_message !== want.first_of_message ||
          got.last_of_message !== want.last_of_message || got.error !== want.error) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  rcd_in_if in_ch(clk);
  rcd_out_if out_ch(clk);
  rcd_cfg_if cfg_ch(clk);

  rtmp_chunk_deframer_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  deframe_scoreboard sb = new();
  bit quiet = 1'b0;
  int sent = 0;

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = 1'b0; in_ch.stream_byte = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // result side: random stalls, transfer seen at negedge, checked at the edge
  initial begin
    int stall;
    bit hs;
    rcd_pkg::result_t d;
    stall = 0;
    forever begin
      @(negedge clk);
      hs = out_ch.valid && out_ch.ready && rst_n;
      d = out_ch.data;
      @(posedge clk);
      if (hs) begin
        sb.check_result(d);
        stall = quiet ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic send(logic m, logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.stream_byte <= b;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    sb.note_input(m, b);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [23:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
    end
    @(posedge clk);
    sb.init_size = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_header(logic [1:0] f, logic [5:0] c, logic [23:0] ts,
                             logic [23:0] ln, logic [7:0] ty);
    send(1'b0, {f, c});
    if (f == 2'd3) return;
    for (int k = 0; k < 3; k++) send(1'b0, ts[23 - 8 * k -: 8]);
    if (f == 2'd2) return;
    for (int k = 0; k < 3; k++) send(1'b0, ln[23 - 8 * k -: 8]);
    send(1'b0, ty);
    if (f == 2'd1) return;
    for (int k = 0; k < 4; k++) send(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(logic [31:0] lead, bit use_lead);
    int k;
    k = 0;
    while (sb.pos == rcd_pkg::POS_PAYLOAD && k < 200) begin
      send(1'b0, (use_lead && k < 4) ? lead[31 - 8 * k -: 8]
                                     : 8'($urandom_range(0, 255)));
      k++;
    end
  endtask

  task automatic gen_message();
    logic [5:0] c;
    logic [1:0] f;
    logic [23:0] ln;
    logic [7:0] ty;
    logic [31:0] lead;
    int s;
    bit sz;
    c = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(2, 63)) : 6'($urandom_range(2, 9));
    s = sb.find(c);
    sz = 1'b0;
    lead = $urandom;
    if (s >= 0 && sb.slot_rem[s] != 24'd0 && $urandom_range(0, 9) < 7) begin
      f = 2'd3;
    end else begin
      f = 2'($urandom_range(0, 3));
      if ((s < 0 || !sb.slot_kn[s]) && f >= 2'd2 && $urandom_range(0, 4) != 0) f = 2'd0;
    end
    case ($urandom_range(0, 19))
      0: ln = 24'($urandom_range(0, 24'hffffff));
      1, 2: ln = 24'($urandom_range(13, 40));
      default: ln = 24'($urandom_range(0, 12));
    endcase
    ty = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) == 0) begin
      ty = 8'd1;
      ln = 24'($urandom_range(3, 6));
      sz = 1'b1;
      case ($urandom_range(0, 5))
        0: lead = '0;
        1: lead = 32'h8000_0000 | $urandom_range(0, 3);
        2: lead = $urandom;
        default: lead = $urandom_range(1, 40);
      endcase
    end
    send_header(f, c, ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hffffff))
                                                   : 24'($urandom_range(0, 300)), ln, ty);
    send_payload(lead, sz);
  endtask

  initial begin
    logic [23:0] sizes[5];
    sizes = '{24'd128, 24'd1, 24'hffffff, 24'd0, 24'd0};
    sizes[3] = 24'($urandom_range(2, 40));
    sizes[4] = 24'($urandom_range(1, 8));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_header(2'd0, 6'd2, 24'hffffff, 24'd3, 8'hff);
    send_payload(32'h00ff_8000, 1'b1);
    send_header(2'd3, 6'd2, 24'd0, 24'd0, 8'd0);
    send_payload(32'd0, 1'b0);
    send(1'b0, 8'h00);
    send(1'b0, 8'h41);
    send(1'b0, 8'h85);
    send(1'b0, 8'hc6);
    send_header(2'd1, 6'd3, 24'd0, 24'd4, 8'd1);
    send_payload(32'h0000_0002, 1'b1);
    send_header(2'd2, 6'd3, 24'd5, 24'd0, 8'd0);
    send_payload(32'd0, 1'b0);
    send(1'b1, 8'h00);
    for (int i = 2; i <= 10; i++) send(1'b0, {2'd3, i[5:0]});
    send(1'b1, 8'h00);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_size(sizes[p]);
      send(1'b1, 8'h00);
      quiet = (p == 1);
      while (sent < 350 * (p + 1)) begin
        if (p == 3 && sent >= 350 * p + 175 && sent < 350 * p + 185) begin
          drain();
          sent += 10;
        end
        case ($urandom_range(0, 19))
          0: send(1'b1, 8'($urandom_range(0, 255)));
          1, 2: repeat ($urandom_range(1, 4)) send(1'b0, 8'($urandom_range(0, 255)));
          default: gen_message();
        endcase
      end
      quiet = 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

[sim.f]
sv/rcd_pkg.sv
sv/rcd_if.sv
sv/rtmp_chunk_deframer_unit.sv
sim/rtmp_chunk_deframer_unit_tb.sv
